@@ hdl/emgc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// emgc_pkg: shared types and helpers for the graph connectivity unit
// Field widths, the control word sent to the reach cells, and the
// pair-to-mask-bit lookup used to build each node's adjacency row.
// ----------------------------------------------------------------------------
package emgc_pkg;

    localparam int NUM_W      = 4;
    localparam int EDGE_W     = 28;
    localparam int EDGE_IDX_W = 5;

    typedef struct packed {
        logic load;
        logic shift;
    } emgc_ctrl_t;

    // Mask bit for pair (a,b), a<b, in an n-node upper triangle.
    // Pairs past the node count or past the mask width read as absent.
    function automatic logic pair_bit(input logic [EDGE_W-1:0] edges,
                                      input logic [NUM_W-1:0]  n,
                                      input int                a,
                                      input int                b);
        int   nn;
        int   pos;
        logic bit_val;
        nn      = int'(n);
        pos     = a * (nn - 1) - ((a * (a - 1)) >>> 1) + (b - a - 1);
        bit_val = 1'b0;
        if (b < nn && pos >= 0 && pos < EDGE_W)
        begin
            bit_val = edges[pos[EDGE_IDX_W-1:0]];
        end
        return bit_val;
    endfunction

endpackage
`default_nettype wire

@@ hdl/emgc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// emgc_cell: one node of the reach ring
// Holds the node's adjacency row and one slot of the circulating reach
// vector. When the vector passes through a reached node, its row is merged.
// ----------------------------------------------------------------------------
module emgc_cell
    import emgc_pkg::*;
#(
    parameter int MAX_OBJECTS = 8,
    parameter int INDEX       = 0
)
(
    input  wire logic                   clk,
    input  wire emgc_ctrl_t             ctl,
    input  wire logic [NUM_W-1:0]       num_objects,
    input  wire logic [EDGE_W-1:0]      edges,
    input  wire logic [MAX_OBJECTS-1:0] vec_in,
    output logic      [MAX_OBJECTS-1:0] vec_out
);

    logic [MAX_OBJECTS-1:0] row;
    logic [MAX_OBJECTS-1:0] adj_reg;
    logic [MAX_OBJECTS-1:0] vec_reg;
    logic [MAX_OBJECTS-1:0] vec_next;

    always_comb
    begin
        for (int j = 0; j < MAX_OBJECTS; j++)
        begin
            if (j > INDEX)
            begin
                row[j] = pair_bit(edges, num_objects, INDEX, j);
            end
            else if (j < INDEX)
            begin
                row[j] = pair_bit(edges, num_objects, j, INDEX);
            end
            else
            begin
                row[j] = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (ctl.load)
        begin
            vec_next = vec_in;
        end
        else
        begin
            vec_next = vec_in | (vec_in[INDEX] ? adj_reg : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            adj_reg <= row;
        end
        if (ctl.load || ctl.shift)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule
`default_nettype wire

@@ hdl/emgc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// emgc_ctrl: sequencer for the reach ring
// Takes a beat, runs the ring for N full turns (one turn for a bad node count), checks the reach vector
// against the node mask and holds the result until the output beat is taken.
// ----------------------------------------------------------------------------
module emgc_ctrl
    import emgc_pkg::*;
#(
    parameter int MAX_OBJECTS = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [NUM_W-1:0]       num_objects,
    input  wire logic [MAX_OBJECTS-1:0] reach,
    output emgc_ctrl_t                  ctl,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        connected
);

    localparam int CYC_W = $clog2(MAX_OBJECTS);
    localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(MAX_OBJECTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_CHECK,
        ST_HOLD
    } state_t;

    state_t           state_reg, state_next;
    logic [CYC_W-1:0] cyc_reg, cyc_next;
    logic [NUM_W-1:0] sweep_reg, sweep_next;
    logic [NUM_W-1:0] limit_reg, limit_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic             nvalid_reg, nvalid_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic             connected_reg, connected_next;

    logic                   n_ok;
    logic                   out_free;
    logic [MAX_OBJECTS-1:0] all_mask;
    logic                   result;

    assign n_ok     = (num_objects != '0) && (num_objects <= NUM_W'(MAX_OBJECTS));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        for (int i = 0; i < MAX_OBJECTS; i++)
        begin
            all_mask[i] = (i < int'(n_reg));
        end
    end

    assign result = nvalid_reg && ((reach & all_mask) == all_mask);

    always_comb
    begin
        state_next     = state_reg;
        cyc_next       = cyc_reg;
        sweep_next     = sweep_reg;
        limit_next     = limit_reg;
        n_next         = n_reg;
        nvalid_next    = nvalid_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        connected_next = connected_reg;
        ctl            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load    = 1'b1;
                    n_next      = num_objects;
                    nvalid_next = n_ok;
                    // bad node counts still take one turn, result forced low
                    limit_next  = n_ok ? num_objects : NUM_W'(1);
                    cyc_next    = '0;
                    sweep_next  = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.shift = 1'b1;
                if (cyc_reg == CYC_LAST)
                begin
                    cyc_next = '0;
                    if (sweep_reg == limit_reg - NUM_W'(1))
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + NUM_W'(1);
                    end
                end
                else
                begin
                    cyc_next = cyc_reg + CYC_W'(1);
                end
            end
            ST_CHECK:
            begin
                // token is back in cell 0 here
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    connected_next = result;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pend_next  = result;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    connected_next = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cyc_reg       <= '0;
            sweep_reg     <= '0;
            limit_reg     <= NUM_W'(1);
            n_reg         <= '0;
            nvalid_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            connected_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cyc_reg       <= cyc_next;
            sweep_reg     <= sweep_next;
            limit_reg     <= limit_next;
            n_reg         <= n_next;
            nvalid_reg    <= nvalid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            connected_reg <= connected_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign connected = connected_reg;

`ifndef ASSERT_OFF
    a_cyc_range: assert property (@(posedge clk) disable iff (!rst_n)
        cyc_reg <= CYC_LAST)
        else $error("turn counter past last cell");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> sweep_reg < limit_reg)
        else $error("turn counter past limit");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_RUN && ctl.shift)
        else $error("accepted beat did not start the ring");

    a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK && !nvalid_reg && out_free |=> out_valid && !connected)
        else $error("invalid node count reported connected");

    a_single_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK && nvalid_reg && n_reg == NUM_W'(1) && out_free
        |=> out_valid && connected)
        else $error("single node reported unconnected");
`endif

endmodule
`default_nettype wire

@@ hdl/edge_mask_graph_connectivity_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edge_mask_graph_connectivity_unit: undirected graph connectivity check
// Reports whether every node of an edge-mask graph is reachable from node 0.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each node owns a cell in a ring of
// MAX_OBJECTS cells; a reach vector seeded with node 0 travels around the
// ring one cell per cycle, picking up the adjacency row of every reached node.
// The ring makes N full turns: an item is loaded, carried around the ring
// for those N turns and then checked against the node mask;
// a node count of 0 or above MAX_OBJECTS takes one turn and reports 0.
// The next beat is taken once the result has moved into the output register,
// even if that result has not yet been taken downstream.
module edge_mask_graph_connectivity_unit
    import emgc_pkg::*;
#(
    parameter int MAX_OBJECTS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [NUM_W-1:0]  num_objects,
    input  wire logic [EDGE_W-1:0] edges,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   connected
);

    localparam logic [MAX_OBJECTS-1:0] SEED = MAX_OBJECTS'(1);

    emgc_ctrl_t             ctl;
    logic [MAX_OBJECTS-1:0] vec [MAX_OBJECTS];
    logic [MAX_OBJECTS-1:0] ring_head;

    assign ring_head = ctl.load ? SEED : vec[MAX_OBJECTS-1];

    for (genvar k = 0; k < MAX_OBJECTS; k++)
    begin : g_cell
        emgc_cell #(
            .MAX_OBJECTS (MAX_OBJECTS),
            .INDEX       (k)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .num_objects (num_objects),
            .edges       (edges),
            .vec_in      ((k == 0) ? ring_head : vec[(k == 0) ? 0 : k - 1]),
            .vec_out     (vec[k])
        );
    end

    emgc_ctrl #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .num_objects (num_objects),
        .reach       (vec[0]),
        .ctl         (ctl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .connected   (connected)
    );

endmodule
`default_nettype wire
